/* rtl/tfprm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tfprm_pkg;

  localparam int COUNT_BITS = 24;
  localparam int NUM_SPACES = 16;

  localparam int PIXEL_W    = 32;
  localparam int COORD_W    = 12;
  localparam int LEVEL_W    = 4;
  localparam int ID_W       = 4;
  localparam int DIM_W      = 2;
  localparam int ADDR_W     = 24;
  localparam int REQ_W      = 24;
  localparam int SHIFT_W    = 6;

  localparam int MAXL_TBL_W = NUM_SPACES * LEVEL_W;
  localparam int DIM_TBL_W  = NUM_SPACES * DIM_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = MAXL_TBL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 2'd1;

  localparam logic [PIXEL_W-1:0]    SKIP_WORD      = '1;
  localparam logic [MAXL_TBL_W-1:0] MAXL_TBL_RESET = '1;
  localparam logic [DIM_TBL_W-1:0]  DIM_TBL_RESET  = {NUM_SPACES{2'b10}};

  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int OBUF_DEPTH = 2;
  localparam int OPTR_W     = 1;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               skip;
    logic               frame_end;
    logic [ID_W-1:0]    space_id;
    logic [LEVEL_W-1:0] level;
    logic [ADDR_W-1:0]  addr;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]    space_id;
    logic [LEVEL_W-1:0] level;
    logic [ADDR_W-1:0]  addr;
    logic [REQ_W-1:0]   count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [QPTR_W:0] count;
  } q_status_t;

  typedef struct packed {
    logic          run_valid;
    logic [OPTR_W:0] ocount;
  } bk_status_t;

  // Put x on the even bits and y on the odd bits.
  function automatic logic [ADDR_W-1:0] interleave(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int i = 0; i < COORD_W; i++) begin
      r[2*i]   = x[i];
      r[2*i+1] = y[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/tfprm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module tfprm_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire [tfprm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tfprm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire [tfprm_pkg::PIXEL_W-1:0]      in_pixel,
  input  wire                               in_frame_end,
  output tfprm_pkg::item_t                  item
);
  import tfprm_pkg::*;

  logic [MAXL_TBL_W-1:0] max_level_r;
  logic [DIM_TBL_W-1:0]  dimension_r;

  logic [COORD_W-1:0] px, py;
  logic [LEVEL_W-1:0] lvl_raw, lvl_max, lvl;
  logic [ID_W-1:0]    id;
  logic [DIM_W-1:0]   dims;
  logic [SHIFT_W-1:0] shift;
  logic [ADDR_W-1:0]  morton, mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_level_r <= MAXL_TBL_RESET;
      dimension_r <= DIM_TBL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAX_LEVEL) begin
        max_level_r <= cfg_wdata;
      end else if (cfg_index == CFG_DIMENSION) begin
        dimension_r <= cfg_wdata[DIM_TBL_W-1:0];
      end
    end
  end

  always_comb begin
    px      = in_pixel[COORD_W-1:0];
    py      = in_pixel[2*COORD_W-1:COORD_W];
    lvl_raw = in_pixel[2*COORD_W+LEVEL_W-1:2*COORD_W];
    id      = in_pixel[PIXEL_W-1:PIXEL_W-ID_W];
    lvl_max = max_level_r[id*LEVEL_W +: LEVEL_W];
    dims    = dimension_r[id*DIM_W +: DIM_W];
    lvl     = (lvl_raw > lvl_max) ? lvl_max : lvl_raw;
    shift   = SHIFT_W'(dims) * SHIFT_W'(lvl);
    morton  = interleave(px, py);
    // a shift past the address width clears the whole address
    mask    = (shift >= SHIFT_W'(ADDR_W)) ? '0 : ({ADDR_W{1'b1}} << shift);

    item.pixel     = in_pixel;
    item.skip      = (in_pixel == SKIP_WORD);
    item.frame_end = in_frame_end;
    item.space_id  = id;
    item.level     = lvl;
    item.addr      = morton & mask;
  end

endmodule
`default_nettype wire

/* rtl/tfprm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module tfprm_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  tfprm_pkg::item_t     push_item,
  output logic                 can_push,
  input  wire                  pop,
  output logic                 head_valid,
  output tfprm_pkg::item_t     head_item,
  output tfprm_pkg::q_status_t status
);
  import tfprm_pkg::*;

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_item;
  end

  assign can_push     = (count_r != (QPTR_W+1)'(QDEPTH));
  assign head_valid   = (count_r != '0);
  assign head_item    = slot_r[rp_r];
  assign status.count = count_r;

endmodule
`default_nettype wire

/* rtl/tfprm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module tfprm_back (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                head_valid,
  input  tfprm_pkg::item_t                   head_item,
  output logic                               pop,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [tfprm_pkg::ID_W-1:0]         out_space_id,
  output logic [tfprm_pkg::LEVEL_W-1:0]      out_mip_level,
  output logic [tfprm_pkg::ADDR_W-1:0]       out_page_address,
  output logic [tfprm_pkg::REQ_W-1:0]        out_request_count,
  output logic                               out_last_of_item,
  output tfprm_pkg::bk_status_t              status
);
  import tfprm_pkg::*;

  logic [PIXEL_W-1:0]    prev_r, prev_nxt;
  logic                  run_valid_r, run_valid_nxt;
  logic [ID_W-1:0]       run_id_r, run_id_nxt;
  logic [LEVEL_W-1:0]    run_lvl_r, run_lvl_nxt;
  logic [ADDR_W-1:0]     run_addr_r, run_addr_nxt;
  logic [COUNT_BITS-1:0] run_count_r, run_count_nxt;

  // state after the pixel, before the frame-end flush
  logic [PIXEL_W-1:0]    mid_prev;
  logic                  mid_valid;
  logic [ID_W-1:0]       mid_id;
  logic [LEVEL_W-1:0]    mid_lvl;
  logic [ADDR_W-1:0]     mid_addr;
  logic [COUNT_BITS-1:0] mid_count;
  logic [COUNT_BITS-1:0] bumped;

  logic    merge, emit_old, emit_flush;
  logic [1:0] need;
  logic [2:0] free;
  logic    opop;
  result_t old_res, flush_res;

  result_t         obuf_r [OBUF_DEPTH];
  logic [OPTR_W-1:0] owp_r, orp_r;
  logic [OPTR_W:0]   ocount_r;

  always_comb begin
    bumped = (run_count_r == '1) ? run_count_r : run_count_r + 1'b1;
    merge  = run_valid_r && ((head_item.pixel == prev_r) ||
             (head_item.space_id == run_id_r && head_item.level == run_lvl_r &&
              head_item.addr == run_addr_r));

    mid_prev  = prev_r;
    mid_valid = run_valid_r;
    mid_id    = run_id_r;
    mid_lvl   = run_lvl_r;
    mid_addr  = run_addr_r;
    mid_count = run_count_r;
    if (!head_item.skip) begin
      if (merge) begin
        mid_count = bumped;
      end else begin
        mid_prev  = head_item.pixel;
        mid_valid = 1'b1;
        mid_id    = head_item.space_id;
        mid_lvl   = head_item.level;
        mid_addr  = head_item.addr;
        mid_count = COUNT_BITS'(1);
      end
    end

    emit_old   = !head_item.skip && !merge && run_valid_r;
    emit_flush = head_item.frame_end && mid_valid;
    need       = 2'(emit_old) + 2'(emit_flush);

    opop = out_valid && out_ready;
    free = 3'(OBUF_DEPTH) - 3'(ocount_r) + 3'(opop);
    pop  = head_valid && (free >= 3'(need));

    old_res.space_id = run_id_r;
    old_res.level    = run_lvl_r;
    old_res.addr     = run_addr_r;
    old_res.count    = REQ_W'(run_count_r);
    old_res.last     = !emit_flush;

    flush_res.space_id = mid_id;
    flush_res.level    = mid_lvl;
    flush_res.addr     = mid_addr;
    flush_res.count    = REQ_W'(mid_count);
    flush_res.last     = 1'b1;

    if (head_item.frame_end) begin
      prev_nxt      = SKIP_WORD;
      run_valid_nxt = 1'b0;
      run_id_nxt    = '0;
      run_lvl_nxt   = '0;
      run_addr_nxt  = '0;
      run_count_nxt = '0;
    end else begin
      prev_nxt      = mid_prev;
      run_valid_nxt = mid_valid;
      run_id_nxt    = mid_id;
      run_lvl_nxt   = mid_lvl;
      run_addr_nxt  = mid_addr;
      run_count_nxt = mid_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= SKIP_WORD;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
      run_lvl_r   <= '0;
      run_addr_r  <= '0;
      run_count_r <= '0;
    end else if (pop) begin
      prev_r      <= prev_nxt;
      run_valid_r <= run_valid_nxt;
      run_id_r    <= run_id_nxt;
      run_lvl_r   <= run_lvl_nxt;
      run_addr_r  <= run_addr_nxt;
      run_count_r <= run_count_nxt;
    end
  end

  // output buffer: up to two words written per item
  always_ff @(posedge clk) begin
    if (pop) begin
      if (emit_old) begin
        obuf_r[owp_r] <= old_res;
        if (emit_flush) obuf_r[owp_r + 1'b1] <= flush_res;
      end else if (emit_flush) begin
        obuf_r[owp_r] <= flush_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r    <= '0;
      orp_r    <= '0;
      ocount_r <= '0;
    end else begin
      if (pop) owp_r <= owp_r + OPTR_W'(need);
      if (opop) orp_r <= orp_r + 1'b1;
      ocount_r <= ocount_r + (OPTR_W+1)'(pop ? need : 2'd0) - (OPTR_W+1)'(opop);
    end
  end

  assign out_valid         = (ocount_r != '0);
  assign out_space_id      = obuf_r[orp_r].space_id;
  assign out_mip_level     = obuf_r[orp_r].level;
  assign out_page_address  = obuf_r[orp_r].addr;
  assign out_request_count = obuf_r[orp_r].count;
  assign out_last_of_item  = obuf_r[orp_r].last;

  assign status.run_valid = run_valid_r;
  assign status.ocount    = ocount_r;

endmodule
`default_nettype wire

/* rtl/texture_feedback_page_run_merge_top.sv */
// A pixel accepted into the queue passes the queue and then the output buffer register before
// any result that it gives can be handed over; out_valid comes from the output buffer count.
// Throughput: one pixel per cycle while the queue and the output buffer have room; an item that
// closes a run and flushes at frame end gives two words, which leave the output buffer one at a time.
// The back end takes one queued pixel per cycle while the two-word output buffer has room.
// Reset (rst_n low, synchronous): run state, queue and output buffer clear;
// both tables return to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module texture_feedback_page_run_merge_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [tfprm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [tfprm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [tfprm_pkg::PIXEL_W-1:0]       in_pixel,
  input  wire                                in_frame_end,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [tfprm_pkg::ID_W-1:0]         out_space_id,
  output logic [tfprm_pkg::LEVEL_W-1:0]      out_mip_level,
  output logic [tfprm_pkg::ADDR_W-1:0]       out_page_address,
  output logic [tfprm_pkg::REQ_W-1:0]        out_request_count,
  output logic                               out_last_of_item
);
  import tfprm_pkg::*;

  item_t      dec_item, head_item;
  logic       head_valid, pop, push;
  q_status_t  q_status;
  bk_status_t bk_status;

  assign push = in_valid && in_ready;

  tfprm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_pixel     (in_pixel),
    .in_frame_end (in_frame_end),
    .item         (dec_item)
  );

  tfprm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (dec_item),
    .can_push   (in_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .status     (q_status)
  );

  tfprm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_item         (head_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_space_id      (out_space_id),
    .out_mip_level     (out_mip_level),
    .out_page_address  (out_page_address),
    .out_request_count (out_request_count),
    .out_last_of_item  (out_last_of_item),
    .status            (bk_status)
  );

`ifndef ASSERT_OFF
  // never overfill the queue or the output buffer
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.count <= (QPTR_W+1)'(QDEPTH) && bk_status.ocount <= (OPTR_W+1)'(OBUF_DEPTH))
    else $error("queue or output buffer overfilled");

  // a frame-end word leaves no open run behind
  a_frame_flush: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_item.frame_end |=> !bk_status.run_valid)
    else $error("run still open after frame end");

  // a pixel pushed into an empty pipe cannot reach the output in the cycle after its push
  a_no_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.count == '0 && bk_status.ocount == '0 |=> !out_valid)
    else $error("result appeared without passing the queue");
`endif

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import tfprm_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]    space_id;
    logic [LEVEL_W-1:0] level;
    logic [ADDR_W-1:0]  addr;
    logic [REQ_W-1:0]   count;
    logic               last;
  } page_run_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_LEVEL;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIXEL_W-1:0]    in_pixel = '0;
  logic                  in_frame_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ID_W-1:0]       out_space_id;
  logic [LEVEL_W-1:0]    out_mip_level;
  logic [ADDR_W-1:0]     out_page_address;
  logic [REQ_W-1:0]      out_request_count;
  logic                  out_last_of_item;

  texture_feedback_page_run_merge_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel          (in_pixel),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_space_id      (out_space_id),
    .out_mip_level     (out_mip_level),
    .out_page_address  (out_page_address),
    .out_request_count (out_request_count),
    .out_last_of_item  (out_last_of_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;

  // Mirror of the block's tables and run state.
  logic [MAXL_TBL_W-1:0] lvl_limits = MAXL_TBL_RESET;
  logic [DIM_TBL_W-1:0]  dim_counts = DIM_TBL_RESET;
  logic [PIXEL_W-1:0]    prev_word = SKIP_WORD;
  logic                  run_open = 1'b0;
  logic [ID_W-1:0]       run_id = '0;
  logic [LEVEL_W-1:0]    run_lvl = '0;
  logic [ADDR_W-1:0]     run_addr = '0;
  logic [COUNT_BITS-1:0] run_cnt = '0;

  page_run_t pending_runs[$];
  page_run_t next_run;

  task automatic merge_pixel(input logic [PIXEL_W-1:0] px, input logic fe);
    logic [ID_W-1:0]    id;
    logic [LEVEL_W-1:0] lvl;
    logic [LEVEL_W-1:0] lim;
    logic [DIM_W-1:0]   dims;
    logic [ADDR_W-1:0]  addr;
    int                 shift;
    int                 n;
    page_run_t          closed [2];
    n = 0;
    if (px != SKIP_WORD) begin
      if (run_open && px == prev_word) begin
        if (run_cnt != '1) run_cnt = run_cnt + 1'b1;
      end else begin
        id   = px[31:28];
        lvl  = px[27:24];
        lim  = lvl_limits[4*id +: 4];
        dims = dim_counts[2*id +: 2];
        for (int i = 0; i < COORD_W; i++) begin
          addr[2*i]   = px[i];
          addr[2*i+1] = px[COORD_W+i];
        end
        if (lvl > lim) lvl = lim;
        shift = int'(dims) * int'(lvl);
        if (shift >= ADDR_W) addr = '0;
        else addr = addr & ({ADDR_W{1'b1}} << shift);
        if (run_open && id == run_id && lvl == run_lvl && addr == run_addr) begin
          if (run_cnt != '1) run_cnt = run_cnt + 1'b1;
        end else begin
          if (run_open) begin
            closed[n] = '{run_id, run_lvl, run_addr, REQ_W'(run_cnt), 1'b0};
            n++;
          end
          prev_word = px;
          run_open  = 1'b1;
          run_id    = id;
          run_lvl   = lvl;
          run_addr  = addr;
          run_cnt   = 1;
        end
      end
    end
    // Frame end: flush whatever is pending, then forget the frame.
    if (fe) begin
      if (run_open) begin
        closed[n] = '{run_id, run_lvl, run_addr, REQ_W'(run_cnt), 1'b0};
        n++;
      end
      prev_word = SKIP_WORD;
      run_open  = 1'b0;
      run_id    = '0;
      run_lvl   = '0;
      run_addr  = '0;
      run_cnt   = '0;
    end
    if (n > 0) closed[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_runs.push_back(closed[i]);
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic fe);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pixel     <= px;
    in_frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    merge_pixel(px, fe);
  endtask

  // Hold the input until every expected word is out, then let the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tables(input logic [MAXL_TBL_W-1:0] maxl, input logic [DIM_TBL_W-1:0] dims);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_LEVEL;
    cfg_wdata <= maxl;
    @(posedge clk);
    cfg_index <= CFG_DIMENSION;
    cfg_wdata <= CFG_DATA_W'(dims);
    @(posedge clk);
    cfg_we     <= 1'b0;
    lvl_limits  = maxl;
    dim_counts  = dims;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_runs.size() == 0) begin
        errors++;
        $display("%0t: word with nothing expected: id %0h lvl %0h addr %0h cnt %0h last %0b",
                 $time, out_space_id, out_mip_level, out_page_address, out_request_count,
                 out_last_of_item);
      end else begin
        next_run = pending_runs.pop_front();
        check_field("space_id", next_run.space_id, out_space_id);
        check_field("mip_level", next_run.level, out_mip_level);
        check_field("page_address", next_run.addr, out_page_address);
        check_field("request_count", next_run.count, out_request_count);
        check_field("last_of_item", next_run.last, out_last_of_item);
      end
    end
  end

  // Default tables: runs, skips, frame flushes and two-word items.
  task automatic test_basic_runs();
    send_pixel(SKIP_WORD, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(SKIP_WORD, 1'b0);
    send_pixel(32'h0100_0001, 1'b0);
    send_pixel(32'h0100_1000, 1'b0);
    send_pixel(32'hffff_fffe, 1'b0);
    send_pixel(32'hf0ff_ffff, 1'b1);
    send_pixel(32'h0fff_ffff, 1'b0);
    send_pixel(SKIP_WORD, 1'b1);
    send_pixel(32'h0000_0fff, 1'b1);
    send_pixel(32'h00ff_f000, 1'b0);
    send_pixel(32'h00ff_f000, 1'b1);
    drain_results();
  endtask

  // Level clamping and mask shifts at the table extremes.
  task automatic test_table_settings();
    set_tables('0, '0);
    send_pixel(32'h5123_4567, 1'b0);
    send_pixel(32'h5f23_4567, 1'b0);
    send_pixel(32'h5a23_4567, 1'b1);
    drain_results();
    set_tables(64'h0123_4567_89ab_cdef, 32'hffff_ffff);
    send_pixel(32'h0800_0fff, 1'b0);
    send_pixel(32'h0700_0fff, 1'b0);
    send_pixel(32'h1f00_0001, 1'b0);
    send_pixel(32'hf3ff_ffff, 1'b0);
    send_pixel(32'he5ab_cdef, 1'b1);
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_items, input int idle, input int stall,
                                     input logic [MAXL_TBL_W-1:0] maxl,
                                     input logic [DIM_TBL_W-1:0] dims);
    logic [PIXEL_W-1:0] cur;
    logic [PIXEL_W-1:0] px;
    int                 pick;
    drain_results();
    set_tables(maxl, dims);
    idle_pct  = idle;
    stall_pct = stall;
    cur = $urandom;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        px = cur;
      end else if (pick < 50) begin
        // nudge the low coordinate bits; often lands on the same page
        cur = cur ^ {8'h00, 10'h000, 2'($urandom), 10'h000, 2'($urandom)};
        px  = cur;
      end else if (pick < 60) begin
        px = SKIP_WORD;
      end else if (pick < 90) begin
        cur = $urandom;
        px  = cur;
      end else begin
        px = $urandom;
      end
      send_pixel(px, $urandom_range(99) < 8);
      if (i == n_items / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_runs();
    test_table_settings();
    test_random_traffic(110, 0, 0, '0, '0);
    test_random_traffic(110, 58, 0, '1, '1);
    test_random_traffic(110, 0, 58, {$urandom, $urandom}, $urandom);
    test_random_traffic(110, 21, 21, {$urandom, $urandom}, 32'h5555_5555);
    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_runs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
